/* sv/gsa_pkg.sv */
// Shared types, codes and constants of the generational slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

	localparam int unsigned GSA_MAX_SLOTS  = 64;
	localparam int unsigned GSA_GEN_BITS   = 8;
	localparam int unsigned GSA_TYPE_BITS  = 6;
	localparam int unsigned GSA_MAX_STATIC = 256;

	localparam int unsigned OP_W       = 3;
	localparam int unsigned SLOT_W     = 9;
	localparam int unsigned GEN_W      = 8;
	localparam int unsigned TAG_W      = 6;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned STATIC_W   = 9;
	localparam int unsigned RESV_W     = 7;
	localparam int unsigned ACTIVE_W   = 7;

	localparam int unsigned ACTIVE_RESET = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_ALLOC_AT = 3'd1,
		OP_FREE     = 3'd2,
		OP_RESOLVE  = 3'd3,
		OP_LOOKUP   = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_MISS   = 3'd2,
		ST_STATIC = 3'd3,
		ST_FREED  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STATIC_COUNT   = 2'd0,
		CFG_RESERVED_COUNT = 2'd1,
		CFG_ACTIVE_SLOTS   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic    valid;
		logic    done;
		status_t status;
	} gsa_tok_t;

endpackage

`default_nettype wire

/* sv/gsa_if.sv */
// Handshake channel interfaces for requests, responses and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface gsa_req_if;
	import gsa_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [SLOT_W-1:0] slot;
	logic [GEN_W-1:0]  generation;
	logic [TAG_W-1:0]  type_tag;

	modport source (output valid, operation, slot, generation, type_tag, input ready);
	modport sink (input valid, operation, slot, generation, type_tag, output ready);
endinterface

interface gsa_rsp_if;
	import gsa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   handle_slot;
	logic [GEN_W-1:0]    handle_generation;

	modport source (output valid, status, handle_slot, handle_generation, input ready);
	modport sink (input valid, status, handle_slot, handle_generation, output ready);
endinterface

interface gsa_cfg_if;
	import gsa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/gsa_cell.sv */
// One slot cell: holds a slot's used bit, generation and type, and forwards the request token.
`timescale 1ns / 1ps
`default_nettype none

module gsa_cell
	import gsa_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = GSA_MAX_SLOTS,
	parameter int unsigned GEN_BITS  = GSA_GEN_BITS,
	parameter int unsigned TYPE_BITS = GSA_TYPE_BITS,
	parameter int unsigned INDEX     = 0,
	localparam int unsigned IDX_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  op_t                  op,
	input  logic [IDX_W-1:0]     target,
	input  logic [GEN_BITS-1:0]  gen_cmp,
	input  logic [TYPE_BITS-1:0] tag,
	input  logic [RESV_W-1:0]    reserved,
	input  logic [ACTIVE_W-1:0]  active,
	input  gsa_tok_t             tok_i,
	input  logic [IDX_W-1:0]     idx_i,
	input  logic [GEN_BITS-1:0]  gen_i,
	output gsa_tok_t             tok_o,
	output logic [IDX_W-1:0]     idx_o,
	output logic [GEN_BITS-1:0]  gen_o
);

	localparam int unsigned CMP_W = (IDX_W > ACTIVE_W) ? IDX_W : ACTIVE_W;
	localparam logic [CMP_W-1:0] MY_CMP = CMP_W'(INDEX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic                 used_q;
	logic [GEN_BITS-1:0]  slot_gen_q;
	logic [TYPE_BITS-1:0] type_q;
	gsa_tok_t             tok_q;
	logic [IDX_W-1:0]     idx_q;
	logic [GEN_BITS-1:0]  gen_q;

	logic                 used_d;
	logic [GEN_BITS-1:0]  slot_gen_d;
	logic                 type_we;
	gsa_tok_t             tok_d;
	logic [IDX_W-1:0]     idx_d;
	logic [GEN_BITS-1:0]  gen_d;
	logic                 eligible;
	logic                 at_target;
	logic                 live;

	assign eligible  = (MY_CMP >= CMP_W'(reserved)) && (MY_CMP < CMP_W'(active));
	assign at_target = (target == MY_IDX);
	assign live      = tok_i.valid && !tok_i.done;

	always_comb begin
		used_d     = used_q;
		slot_gen_d = slot_gen_q;
		type_we    = 1'b0;
		tok_d      = tok_i;
		idx_d      = idx_i;
		gen_d      = gen_i;
		if (tok_i.valid) begin
			unique case (op)
				OP_ALLOC, OP_ALLOC_AT: begin
					if (live && ((op == OP_ALLOC) ? (eligible && !used_q) : at_target)) begin
						used_d       = 1'b1;
						type_we      = 1'b1;
						tok_d.done   = 1'b1;
						tok_d.status = ST_OK;
						idx_d        = MY_IDX;
						gen_d        = slot_gen_q;
					end
				end
				OP_FREE: begin
					if (live && at_target) begin
						tok_d.done = 1'b1;
						if (used_q) begin
							used_d       = 1'b0;
							slot_gen_d   = slot_gen_q + GEN_BITS'(1);
							tok_d.status = ST_OK;
							gen_d        = slot_gen_q + GEN_BITS'(1);
						end else begin
							tok_d.status = ST_FREED;
						end
					end
				end
				OP_RESOLVE: begin
					if (live && at_target) begin
						tok_d.done = 1'b1;
						if (used_q && (slot_gen_q == gen_cmp)) begin
							tok_d.status = ST_OK;
							gen_d        = slot_gen_q;
						end else begin
							tok_d.status = ST_MISS;
						end
					end
				end
				OP_LOOKUP: begin
					if (live && at_target) begin
						tok_d.done = 1'b1;
						if (used_q && (type_q == tag)) begin
							tok_d.status = ST_OK;
							idx_d        = MY_IDX;
							gen_d        = slot_gen_q;
						end else begin
							tok_d.status = ST_MISS;
						end
					end
				end
				OP_CLEAR: begin
					slot_gen_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= 1'b0;
			slot_gen_q <= '0;
			tok_q      <= '0;
		end else begin
			used_q     <= used_d;
			slot_gen_q <= slot_gen_d;
			tok_q      <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		gen_q <= gen_d;
		if (type_we) begin
			type_q <= tag;
		end
	end

	assign tok_o = tok_q;
	assign idx_o = idx_q;
	assign gen_o = gen_q;

endmodule

`default_nettype wire

/* sv/generational_slot_allocator.sv */
// Top level of the generational slot allocator: request decode, row of slot cells, response output.
//
//   Channel   Role     Content
//   req       sink     operation, slot, generation, type_tag
//   rsp       source   status, handle_slot, handle_generation
//   cfg       sink     index, data (register write, always ready)
//
// A request is registered into the launch token, which walks the row of MAX_SLOTS slot cells
// at one cell per cycle; its result then passes the pending and output registers to rsp.
// One request is in flight at a time; the next is accepted once the previous result has moved
// into the output register, so a stalled rsp holds one finished result while the next one runs.
// Reset frees every slot and zeroes every generation at once; type tags are not reset.
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_allocator
	import gsa_pkg::*;
#(
	parameter int unsigned MAX_SLOTS  = GSA_MAX_SLOTS,
	parameter int unsigned GEN_BITS   = GSA_GEN_BITS,
	parameter int unsigned TYPE_BITS  = GSA_TYPE_BITS,
	parameter int unsigned MAX_STATIC = GSA_MAX_STATIC
) (
	input  logic             clk,
	input  logic             arst_n,
	gsa_req_if.sink          req,
	gsa_rsp_if.source        rsp,
	gsa_cfg_if.sink          cfg
);

	localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned ACTIVE_RST = (ACTIVE_RESET > MAX_SLOTS) ? MAX_SLOTS : ACTIVE_RESET;

	logic [STATIC_W-1:0] static_q;
	logic [RESV_W-1:0]   resv_q;
	logic [ACTIVE_W-1:0] active_q;

	logic                 busy_q;
	op_t                  op_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [GEN_BITS-1:0]  gen_cmp_q;
	logic [TYPE_BITS-1:0] tag_q;
	logic [IDX_W-1:0]     target_q;
	gsa_tok_t             launch_tok_q;

	logic                pend_valid_q;
	status_t             pend_status_q;
	logic [SLOT_W-1:0]   pend_hslot_q;
	logic [GEN_W-1:0]    pend_hgen_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [SLOT_W-1:0]   out_hslot_q;
	logic [GEN_W-1:0]    out_hgen_q;

	logic                 accept;
	logic                 move_out;
	op_t                  op_in;
	logic [SLOT_W-1:0]    dyn;
	logic                 below_static;
	logic                 dyn_in_range;
	logic                 in_active;
	logic                 in_reserved;
	gsa_tok_t             launch_tok_d;
	logic [IDX_W-1:0]     target_d;

	gsa_tok_t             tok_w [MAX_SLOTS+1];
	logic [IDX_W-1:0]     idx_w [MAX_SLOTS+1];
	logic [GEN_BITS-1:0]  gen_w [MAX_SLOTS+1];

	status_t              fin_status;
	logic [SLOT_W-1:0]    fin_hslot;
	logic [GEN_W-1:0]     fin_hgen;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_q <= '0;
			resv_q   <= '0;
			active_q <= ACTIVE_W'(ACTIVE_RST);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_STATIC_COUNT: begin
					static_q <= (32'(cfg.data) > MAX_STATIC) ? STATIC_W'(MAX_STATIC)
						: STATIC_W'(cfg.data);
				end
				CFG_RESERVED_COUNT: begin
					resv_q <= cfg.data[RESV_W-1:0];
				end
				CFG_ACTIVE_SLOTS: begin
					active_q <= (32'(cfg.data[ACTIVE_W-1:0]) > MAX_SLOTS)
						? ACTIVE_W'(MAX_SLOTS) : cfg.data[ACTIVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign op_in     = op_t'(req.operation);

	assign below_static = req.slot < static_q;
	assign dyn          = req.slot - static_q;
	assign dyn_in_range = dyn < SLOT_W'(active_q);
	assign in_active    = req.slot < SLOT_W'(active_q);
	assign in_reserved  = req.slot < SLOT_W'(resv_q);

	always_comb begin
		launch_tok_d.valid  = 1'b1;
		launch_tok_d.done   = 1'b1;
		launch_tok_d.status = ST_MISS;
		target_d            = IDX_W'(req.slot);
		unique case (op_in)
			OP_ALLOC: begin
				launch_tok_d.done = 1'b0;
			end
			OP_ALLOC_AT: begin
				if (in_active) begin
					launch_tok_d.done = 1'b0;
				end else begin
					launch_tok_d.status = ST_FULL;
				end
			end
			OP_FREE: begin
				target_d = IDX_W'(dyn);
				if (below_static) begin
					launch_tok_d.status = ST_STATIC;
				end else if (!dyn_in_range) begin
					launch_tok_d.status = ST_FREED;
				end else begin
					launch_tok_d.done = 1'b0;
				end
			end
			OP_RESOLVE: begin
				target_d = IDX_W'(dyn);
				if (below_static) begin
					launch_tok_d.status = (GEN_BITS'(req.generation) == '0) ? ST_OK : ST_MISS;
				end else if (dyn_in_range) begin
					launch_tok_d.done = 1'b0;
				end
			end
			OP_LOOKUP: begin
				if (in_reserved && in_active) begin
					launch_tok_d.done = 1'b0;
				end
			end
			OP_CLEAR: begin
				launch_tok_d.status = ST_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			launch_tok_q <= '0;
		end else begin
			launch_tok_q.valid <= accept;
			if (accept) begin
				busy_q              <= 1'b1;
				launch_tok_q.done   <= launch_tok_d.done;
				launch_tok_q.status <= launch_tok_d.status;
			end else if (move_out) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_in;
			slot_q    <= req.slot;
			gen_cmp_q <= GEN_BITS'(req.generation);
			tag_q     <= TYPE_BITS'(req.type_tag);
			target_q  <= target_d;
		end
	end

	assign tok_w[0] = launch_tok_q;
	assign idx_w[0] = '0;
	assign gen_w[0] = '0;

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		gsa_cell #(
			.MAX_SLOTS (MAX_SLOTS),
			.GEN_BITS  (GEN_BITS),
			.TYPE_BITS (TYPE_BITS),
			.INDEX     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op_q),
			.target   (target_q),
			.gen_cmp  (gen_cmp_q),
			.tag      (tag_q),
			.reserved (resv_q),
			.active   (active_q),
			.tok_i    (tok_w[i]),
			.idx_i    (idx_w[i]),
			.gen_i    (gen_w[i]),
			.tok_o    (tok_w[i+1]),
			.idx_o    (idx_w[i+1]),
			.gen_o    (gen_w[i+1])
		);
	end

	always_comb begin
		if (tok_w[MAX_SLOTS].done) begin
			fin_status = tok_w[MAX_SLOTS].status;
		end else begin
			fin_status = (op_q == OP_ALLOC) ? ST_FULL : ST_MISS;
		end
		fin_hslot = '0;
		fin_hgen  = '0;
		if (fin_status == ST_OK) begin
			unique case (op_q)
				OP_ALLOC, OP_ALLOC_AT, OP_LOOKUP: begin
					fin_hslot = static_q + SLOT_W'(idx_w[MAX_SLOTS]);
					fin_hgen  = GEN_W'(gen_w[MAX_SLOTS]);
				end
				OP_FREE, OP_RESOLVE: begin
					fin_hslot = slot_q;
					fin_hgen  = GEN_W'(gen_w[MAX_SLOTS]);
				end
				default: begin
				end
			endcase
		end
	end

	assign move_out = pend_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (tok_w[MAX_SLOTS].valid) begin
				pend_valid_q <= 1'b1;
			end else if (move_out) begin
				pend_valid_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_w[MAX_SLOTS].valid) begin
			pend_status_q <= fin_status;
			pend_hslot_q  <= fin_hslot;
			pend_hgen_q   <= fin_hgen;
		end
		if (move_out) begin
			out_status_q <= pend_status_q;
			out_hslot_q  <= pend_hslot_q;
			out_hgen_q   <= pend_hgen_q;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_status_q;
	assign rsp.handle_slot       = out_hslot_q;
	assign rsp.handle_generation = out_hgen_q;

endmodule

`default_nettype wire
